/* design/lfdm_pkg.sv */
// Shared types, sizes and codes for the stack/fifo dispatch matcher.
`default_nettype none
package lfdm_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FIFO_DEPTH  = 8;
  localparam int CQ_DEPTH    = 2;

  localparam int S_AW  = $clog2(STACK_DEPTH);
  localparam int S_CW  = $clog2(STACK_DEPTH + 1);
  localparam int F_AW  = $clog2(FIFO_DEPTH);
  localparam int F_CW  = $clog2(FIFO_DEPTH + 1);
  localparam int CQ_AW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CW = $clog2(CQ_DEPTH + 1);

  localparam int ITEM_W = 96;
  localparam int SRV_W  = 24;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_ENQ  = 2'd1;
  localparam logic [1:0] REQ_DISP = 2'd2;

  localparam logic [2:0] ST_PUSHED     = 3'd0;
  localparam logic [2:0] ST_STACK_FULL = 3'd1;
  localparam logic [2:0] ST_ENQUEUED   = 3'd2;
  localparam logic [2:0] ST_FIFO_FULL  = 3'd3;
  localparam logic [2:0] ST_DISPATCHED = 3'd4;
  localparam logic [2:0] ST_NO_ITEM    = 3'd5;
  localparam logic [2:0] ST_NO_SERVER  = 3'd6;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_ENQ  = 2'd2;
  localparam logic [1:0] OP_DISP = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] item_id;
    logic [15:0] dest_code;
    logic [15:0] dim_length;
    logic [15:0] dim_width;
    logic [15:0] dim_height;
    logic [15:0] server_id;
    logic [7:0]  server_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_item_id;
    logic [15:0] out_dest_code;
    logic [15:0] out_length;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [15:0] out_server_id;
    logic [7:0]  out_server_kind;
  } rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] status;
    req_t       req;
  } cmd_t;

endpackage
`default_nettype wire

/* design/lfdm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lfdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/lfdm_cmdq.sv */
// Short command queue between the classifier and the executor.
`default_nettype none
module lfdm_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  input  wire lfdm_pkg::cmd_t wr_cmd,
  output logic               q_full,
  output logic               rd_valid,
  output lfdm_pkg::cmd_t     rd_cmd,
  input  wire logic          rd_take
);

  lfdm_pkg::cmd_t ent [lfdm_pkg::CQ_DEPTH];
  logic [lfdm_pkg::CQ_AW-1:0] wptr;
  logic [lfdm_pkg::CQ_AW-1:0] rptr;
  logic [lfdm_pkg::CQ_CW-1:0] cnt;
  logic do_wr;
  logic do_rd;

  assign q_full   = (cnt == lfdm_pkg::CQ_CW'(lfdm_pkg::CQ_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_cmd   = ent[rptr];
  assign do_wr    = wr_valid && !q_full;
  assign do_rd    = rd_take && rd_valid;

  function automatic logic [lfdm_pkg::CQ_AW-1:0] wrap_inc(input logic [lfdm_pkg::CQ_AW-1:0] p);
    if (p == lfdm_pkg::CQ_AW'(lfdm_pkg::CQ_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wrap_inc(wptr);
      end
      if (do_rd) begin
        rptr <= wrap_inc(rptr);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/lfdm_front.sv */
// Request classifier: tracks occupancy and decides each request's status up front.
`default_nettype none
module lfdm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lfdm_pkg::req_t req,
  output logic                full,
  input  wire logic           q_full,
  output logic                cmd_valid,
  output lfdm_pkg::cmd_t      cmd
);

  // Occupancy as it will be once every queued command has executed.
  logic [lfdm_pkg::S_CW-1:0] scnt;
  logic [lfdm_pkg::S_CW-1:0] scnt_next;
  logic [lfdm_pkg::F_CW-1:0] fcnt;
  logic [lfdm_pkg::F_CW-1:0] fcnt_next;
  logic                      acc;
  logic                      s_full;
  logic                      f_full;

  assign full   = q_full;
  assign acc    = push && !q_full;
  assign s_full = (scnt == lfdm_pkg::S_CW'(lfdm_pkg::STACK_DEPTH));
  assign f_full = (fcnt == lfdm_pkg::F_CW'(lfdm_pkg::FIFO_DEPTH));

  always_comb begin
    cmd        = '0;
    cmd.req    = req;
    cmd.op     = lfdm_pkg::OP_NONE;
    cmd.status = lfdm_pkg::ST_PUSHED;
    cmd_valid  = acc;
    scnt_next  = scnt;
    fcnt_next  = fcnt;
    case (req.req_type)
      lfdm_pkg::REQ_PUSH: begin
        if (s_full) begin
          cmd.status = lfdm_pkg::ST_STACK_FULL;
        end else begin
          cmd.op     = lfdm_pkg::OP_PUSH;
          cmd.status = lfdm_pkg::ST_PUSHED;
          if (acc) begin
            scnt_next = scnt + 1'b1;
          end
        end
      end
      lfdm_pkg::REQ_ENQ: begin
        if (f_full) begin
          cmd.status = lfdm_pkg::ST_FIFO_FULL;
        end else begin
          cmd.op     = lfdm_pkg::OP_ENQ;
          cmd.status = lfdm_pkg::ST_ENQUEUED;
          if (acc) begin
            fcnt_next = fcnt + 1'b1;
          end
        end
      end
      lfdm_pkg::REQ_DISP: begin
        if (scnt == '0) begin
          cmd.status = lfdm_pkg::ST_NO_ITEM;
        end else if (fcnt == '0) begin
          cmd.status = lfdm_pkg::ST_NO_SERVER;
        end else begin
          cmd.op     = lfdm_pkg::OP_DISP;
          cmd.status = lfdm_pkg::ST_DISPATCHED;
          if (acc) begin
            scnt_next = scnt - 1'b1;
            fcnt_next = fcnt - 1'b1;
          end
        end
      end
      default: begin
        // unused request code: taken and dropped, no result
        cmd_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
      fcnt <= '0;
    end else begin
      scnt <= scnt_next;
      fcnt <= fcnt_next;
    end
  end

endmodule
`default_nettype wire

/* design/lfdm_back.sv */
// Executor: stack and fifo storage, read stage and result register.
`default_nettype none
module lfdm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire lfdm_pkg::cmd_t q_cmd,
  output logic                q_take,
  output logic                empty,
  input  wire logic           pop,
  output lfdm_pkg::rsp_t      rsp
);

  logic [lfdm_pkg::S_CW-1:0]   sp;
  logic [lfdm_pkg::S_CW-1:0]   sp_m1;
  logic [lfdm_pkg::F_AW-1:0]   head;
  logic [lfdm_pkg::F_AW-1:0]   tail;
  logic                        issue;
  logic                        out_valid;
  logic                        out_ready;
  logic                        s2_valid;
  logic [2:0]                  s2_status;
  logic                        s2_disp;
  logic                        is_push;
  logic                        is_enq;
  logic                        is_disp;
  logic [lfdm_pkg::ITEM_W-1:0] s_wdata;
  logic [lfdm_pkg::ITEM_W-1:0] s_rdata;
  logic [lfdm_pkg::SRV_W-1:0]  f_wdata;
  logic [lfdm_pkg::SRV_W-1:0]  f_rdata;
  lfdm_pkg::rsp_t              rsp_d;

  function automatic logic [lfdm_pkg::F_AW-1:0] ring_inc(input logic [lfdm_pkg::F_AW-1:0] p);
    if (p == lfdm_pkg::F_AW'(lfdm_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign out_ready = !out_valid || pop;
  assign issue     = q_valid && (!s2_valid || out_ready);
  assign q_take    = issue;
  assign is_push   = issue && (q_cmd.op == lfdm_pkg::OP_PUSH);
  assign is_enq    = issue && (q_cmd.op == lfdm_pkg::OP_ENQ);
  assign is_disp   = issue && (q_cmd.op == lfdm_pkg::OP_DISP);
  assign sp_m1     = sp - 1'b1;
  assign s_wdata   = {q_cmd.req.item_id, q_cmd.req.dest_code, q_cmd.req.dim_length,
                      q_cmd.req.dim_width, q_cmd.req.dim_height};
  assign f_wdata   = {q_cmd.req.server_id, q_cmd.req.server_kind};

  lfdm_ram #(
    .WIDTH(lfdm_pkg::ITEM_W),
    .DEPTH(lfdm_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (is_push),
    .waddr(sp[lfdm_pkg::S_AW-1:0]),
    .wdata(s_wdata),
    .re   (is_disp),
    .raddr(sp_m1[lfdm_pkg::S_AW-1:0]),
    .rdata(s_rdata)
  );

  lfdm_ram #(
    .WIDTH(lfdm_pkg::SRV_W),
    .DEPTH(lfdm_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .we   (is_enq),
    .waddr(tail),
    .wdata(f_wdata),
    .re   (is_disp),
    .raddr(head),
    .rdata(f_rdata)
  );

  // Read data stays put until the next dispatch, which cannot issue before s2 drains.
  always_comb begin
    rsp_d        = '0;
    rsp_d.status = s2_status;
    if (s2_disp) begin
      rsp_d.out_item_id     = s_rdata[95:64];
      rsp_d.out_dest_code   = s_rdata[63:48];
      rsp_d.out_length      = s_rdata[47:32];
      rsp_d.out_width       = s_rdata[31:16];
      rsp_d.out_height      = s_rdata[15:0];
      rsp_d.out_server_id   = f_rdata[23:8];
      rsp_d.out_server_kind = f_rdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      head      <= '0;
      tail      <= '0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (is_push) begin
        sp <= sp + 1'b1;
      end else if (is_disp) begin
        sp <= sp_m1;
      end
      if (is_enq) begin
        tail <= ring_inc(tail);
      end
      if (is_disp) begin
        head <= ring_inc(head);
      end
      if (issue) begin
        s2_valid <= 1'b1;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_status <= q_cmd.status;
      s2_disp   <= (q_cmd.op == lfdm_pkg::OP_DISP);
    end
    if (s2_valid && out_ready) begin
      rsp <= rsp_d;
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

/* design/lifo_fifo_dispatch_matcher.sv */
// Top level: pairs stacked work items with queued servers.
//
// Usage:
//   Requests enter on req as a queue write: a transaction completes on a clock
//   edge with push high and full low. Each request with type push, enqueue or
//   dispatch yields exactly one result on rsp; type 3 is taken and dropped.
//   Results leave as a queue read: rsp is valid while empty is low and a
//   transaction completes on an edge with pop high.
//   A request passes the command queue, the read stage and the result
//   register before its result is readable (empty low from then on).
//   Throughput: one request per cycle while the receiver does not stall, set by
//   the single write/read port on each of the stack and fifo RAMs. The classifier
//   decides the status at intake from its occupancy counts; a two-entry command
//   queue decouples it from the executor, which has a RAM read stage and one
//   result register. When the receiver stalls, the result register, the read
//   stage and the command queue fill in turn, then full rises.
//   Reset (synchronous, rst high) empties stack, fifo and all queues; stored
//   entries are not cleared and need no clearing pass.
`default_nettype none
module lifo_fifo_dispatch_matcher (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire lfdm_pkg::req_t req,
  output logic                empty,
  input  wire logic           pop,
  output lfdm_pkg::rsp_t      rsp
);

  logic           q_full;
  logic           cmd_valid;
  lfdm_pkg::cmd_t cmd;
  logic           q_valid;
  lfdm_pkg::cmd_t q_cmd;
  logic           q_take;

  lfdm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req      (req),
    .full     (full),
    .q_full   (q_full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  lfdm_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(cmd_valid),
    .wr_cmd  (cmd),
    .q_full  (q_full),
    .rd_valid(q_valid),
    .rd_cmd  (q_cmd),
    .rd_take (q_take)
  );

  lfdm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_cmd  (q_cmd),
    .q_take (q_take),
    .empty  (empty),
    .pop    (pop),
    .rsp    (rsp)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.status != lfdm_pkg::ST_DISPATCHED) |->
      (rsp.out_item_id == '0 && rsp.out_dest_code == '0 && rsp.out_length == '0 &&
       rsp.out_width == '0 && rsp.out_height == '0 && rsp.out_server_id == '0 &&
       rsp.out_server_kind == '0))
    else $error("non-dispatch result carries payload");

  a_take_valid: assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("executor took from an empty command queue");

endmodule
`default_nettype wire
